### src/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the max-heap priority queue
// Opcodes, result status codes and the command that steers the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int DATA_W    = 32;

   typedef enum logic {
      OP_INSERT  = 1'b0,
      OP_EXTRACT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_EXTRACT
   } cell_cmd_type;

   // broadcast to every cell of the row
   typedef struct packed {
      cell_cmd_type              cmd;
      logic signed [DATA_W-1:0]  value;
   } cell_ctl_type;

endpackage

`default_nettype wire

### src/mhpq_cell.sv
// ----------------------------------------------------------------------------
// mhpq_cell: one slot of the sorted cell row
// Holds one entry. The row stays sorted largest first; on insert a cell keeps
// its entry, takes the new value or takes its upper neighbor's entry, and on
// extract it takes its lower neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_cell #(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  wire                                      clock,
   input  wire  mhpq_pkg::cell_ctl_type             ctl,
   input  wire  [CNT_W-1:0]                         count,
   input  wire                                      up_above,
   input  wire  signed [mhpq_pkg::DATA_W-1:0]       up_value,
   input  wire  signed [mhpq_pkg::DATA_W-1:0]       down_value,
   output logic signed [mhpq_pkg::DATA_W-1:0]       value,
   output logic                                     above
);

   logic signed [mhpq_pkg::DATA_W-1:0] value_ff;
   logic signed [mhpq_pkg::DATA_W-1:0] value_in;

   // new value belongs at or above this slot (empty slots always qualify)
   assign above = (CNT_W'(INDEX) >= count) || (ctl.value > value_ff);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      unique case (ctl.cmd)
         mhpq_pkg::CMD_INSERT: begin
            if (above) begin
               value_in = up_above ? up_value : ctl.value;
            end
         end
         mhpq_pkg::CMD_EXTRACT: begin
            value_in = down_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

### src/max_heap_priority_queue_top.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top: bounded priority queue of signed 32-bit values
// Insert a value or extract the maximum; one result per item with status and
// occupancy. Entries live in a row of cells kept sorted largest first.
//
//   channel | direction | tdata                           | tuser
//   req     | in        | value [31:0]                    | opcode [0]
//   rsp     | out       | max_value [31:0], occupancy     | status [1:0]
//
// One item per clock while the result is taken: the new value is compared in
// every cell at once and the row shifts by one slot in the same cycle, whatever
// DEPTH is. The result sits in an output register; a new item is taken
// whenever that register is empty or being drained. A stalled result holds
// the input. Synchronous reset empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue_top #(
   parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [31:0]  req_tdata,   // value [31:0]
   input  wire  [0:0]   req_tuser,   // opcode [0]
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // max_value [31:0], occupancy [32 +: clog2(DEPTH+1)], zero pad
   output logic [((mhpq_pkg::DATA_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [1:0]   rsp_tuser    // status [1:0]
);

   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = mhpq_pkg::DATA_W;
   localparam int TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

   logic                        accept;
   logic                        is_full;
   logic                        is_empty;
   mhpq_pkg::op_type            opcode;
   mhpq_pkg::cell_ctl_type      ctl;
   logic signed [DATA_W-1:0]    cell_value [DEPTH];
   logic                        cell_above [DEPTH];

   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [DATA_W-1:0]           max_ff;
   logic [DATA_W-1:0]           max_in;
   mhpq_pkg::status_type        status_ff;
   mhpq_pkg::status_type        status_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign opcode     = mhpq_pkg::op_type'(req_tuser[0]);
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign is_empty   = (count_ff == '0);

   // command, result and next occupancy
   always_comb begin
      ctl.cmd   = mhpq_pkg::CMD_HOLD;
      ctl.value = $signed(req_tdata);
      count_in  = count_ff;
      max_in    = max_ff;
      status_in = status_ff;
      if (accept) begin
         max_in    = '0;
         status_in = mhpq_pkg::ST_OK;
         unique case (opcode)
            mhpq_pkg::OP_INSERT: begin
               if (is_full) begin
                  status_in = mhpq_pkg::ST_FULL;
               end else begin
                  ctl.cmd  = mhpq_pkg::CMD_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            mhpq_pkg::OP_EXTRACT: begin
               if (is_empty) begin
                  status_in = mhpq_pkg::ST_EMPTY;
               end else begin
                  ctl.cmd  = mhpq_pkg::CMD_EXTRACT;
                  max_in   = cell_value[0];
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: begin
               status_in = mhpq_pkg::ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     up_above;
      logic signed [DATA_W-1:0] up_value;
      logic signed [DATA_W-1:0] down_value;

      if (i == 0) begin : g_head
         assign up_above = 1'b0;
         assign up_value = '0;
      end else begin : g_body
         assign up_above = cell_above[i-1];
         assign up_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign down_value = '0;
      end else begin : g_link
         assign down_value = cell_value[i+1];
      end

      mhpq_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .up_above   (up_above),
         .up_value   (up_value),
         .down_value (down_value),
         .value      (cell_value[i]),
         .above      (cell_above[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      max_ff    <= max_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {{(TDATA_W - DATA_W - CNT_W){1'b0}}, count_ff, max_ff};

endmodule

`default_nettype wire

### src/mhpq_checker.sv
// ----------------------------------------------------------------------------
// mhpq_checker: port-level checks of the priority queue
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_checker #(
   parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
   input wire          clock,
   input wire          reset,
   input wire          req_tvalid,
   input wire          req_tready,
   input wire  [0:0]   req_tuser,
   input wire          rsp_tvalid,
   input wire          rsp_tready,
   input wire  [((mhpq_pkg::DATA_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   input wire  [1:0]   rsp_tuser
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = mhpq_pkg::DATA_W;

   logic [CNT_W-1:0]  occupancy;
   logic [DATA_W-1:0] max_value;
   logic              req_xfer;

   assign occupancy = rsp_tdata[DATA_W +: CNT_W];
   assign max_value = rsp_tdata[DATA_W-1:0];
   assign req_xfer  = req_tvalid && req_tready;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == mhpq_pkg::ST_EMPTY |-> rsp_tdata == '0)
      else $error("empty status with nonzero value or occupancy");

   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == mhpq_pkg::ST_FULL
         |-> occupancy == CNT_W'(DEPTH) && max_value == '0)
      else $error("full status with wrong occupancy or value");

   // input is never blocked while the output register is empty
   a_ready_when_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result pending");

   // every transfer in yields a result next cycle with a status that fits its opcode
   a_xfer_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_tvalid &&
         (($past(req_tuser[0]) == mhpq_pkg::OP_EXTRACT)
            ? (rsp_tuser != mhpq_pkg::ST_FULL)
            : (rsp_tuser != mhpq_pkg::ST_EMPTY && max_value == '0)))
      else $error("result missing or status does not fit the opcode");

endmodule

bind max_heap_priority_queue_top mhpq_checker #(
   .DEPTH (DEPTH)
) u_mhpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### tb/tb_max_heap_priority_queue_top.sv
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue_top: self-checking bench of the max-heap queue
// Drives insert and extract items on the req stream and keeps its own binary
// heap to predict each rsp transfer: extracted maximum, status and occupancy.
// Covers the empty and full corner cases, equal keys, sign extremes, a long
// output stall that backs up the input, and random traffic that moves the
// occupancy over its whole range.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_max_heap_priority_queue_top;

   localparam int DEPTH      = mhpq_pkg::DEPTH_DEF;
   localparam int DATA_W     = mhpq_pkg::DATA_W;
   localparam int OCC_W      = $clog2(DEPTH + 1);
   localparam int RSP_W      = ((DATA_W + OCC_W + 7) / 8) * 8;
   localparam int IDLE_PCT   = 15;
   localparam int HOLD_LEN   = 400;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT = 8;

   typedef struct {
      logic signed [DATA_W-1:0] max_value;
      mhpq_pkg::status_type     status;
      logic [OCC_W-1:0]         occupancy;
   } heap_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [31:0]          req_tdata;
   logic [0:0]           req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic [1:0]           rsp_tuser;

   // predictor state
   logic signed [DATA_W-1:0] heap_model [DEPTH];
   int                       heap_count;
   heap_result_type          pending_results [$];

   int mismatch_count;
   bit no_idle;
   int hold_req_id;

   max_heap_priority_queue_top #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic heap_result_type apply_heap_op(mhpq_pkg::op_type op,
                                                     logic signed [DATA_W-1:0] value);
      heap_result_type          res;
      int                       pos;
      int                       parent;
      int                       child;
      logic signed [DATA_W-1:0] tmp;
      res.max_value = '0;
      res.status    = mhpq_pkg::ST_OK;
      if (op == mhpq_pkg::OP_INSERT) begin
         if (heap_count >= DEPTH) begin
            res.status = mhpq_pkg::ST_FULL;
         end else begin
            heap_model[heap_count] = value;
            pos = heap_count;
            heap_count++;
            while (pos != 0) begin
               parent = (pos - 1) / 2;
               if (!(heap_model[pos] > heap_model[parent])) break;
               tmp = heap_model[pos];
               heap_model[pos] = heap_model[parent];
               heap_model[parent] = tmp;
               pos = parent;
            end
         end
      end else begin
         if (heap_count == 0) begin
            res.status = mhpq_pkg::ST_EMPTY;
         end else begin
            res.max_value = heap_model[0];
            heap_count--;
            heap_model[0] = heap_model[heap_count];
            pos = 0;
            // sift toward the larger child, stop on equal keys
            while (pos < heap_count / 2) begin
               child = 2 * pos + 1;
               if (child + 1 < heap_count && heap_model[child + 1] > heap_model[child])
                  child = child + 1;
               if (!(heap_model[child] > heap_model[pos])) break;
               tmp = heap_model[pos];
               heap_model[pos] = heap_model[child];
               heap_model[child] = tmp;
               pos = child;
            end
         end
      end
      res.occupancy = heap_count[OCC_W-1:0];
      return res;
   endfunction

   // mix of full-range, clustered (equal keys) and extreme values
   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(0, 9)) inside
         [0:2]:      v = 32'($signed($urandom_range(0, 15)) - 8);
         3: begin
            case ($urandom_range(0, 5))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7fff_ffff;
               2:       v = 32'h0000_0000;
               3:       v = 32'hffff_ffff;
               4:       v = 32'h8000_0001;
               default: v = 32'h7fff_fffe;
            endcase
         end
         default:    v = $urandom;
      endcase
      return v;
   endfunction

   // offer one item, record its expected result on the accepting edge
   task automatic offer_item(mhpq_pkg::op_type op, logic [31:0] value);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      pending_results.insert(pending_results.size(), apply_heap_op(op, value));
   endtask

   task automatic test_directed();
      offer_item(mhpq_pkg::OP_EXTRACT, $urandom);
      offer_item(mhpq_pkg::OP_EXTRACT, $urandom);
      offer_item(mhpq_pkg::OP_INSERT, 32'h7fff_ffff);
      offer_item(mhpq_pkg::OP_INSERT, 32'h8000_0000);
      offer_item(mhpq_pkg::OP_INSERT, 32'h0000_0000);
      offer_item(mhpq_pkg::OP_INSERT, 32'hffff_ffff);
      offer_item(mhpq_pkg::OP_INSERT, 32'h0000_0005);
      offer_item(mhpq_pkg::OP_INSERT, 32'h0000_0005);
      offer_item(mhpq_pkg::OP_INSERT, 32'h0000_0005);
      offer_item(mhpq_pkg::OP_INSERT, 32'h8000_0000);
      offer_item(mhpq_pkg::OP_INSERT, 32'h0000_0001);
      offer_item(mhpq_pkg::OP_INSERT, 32'hffff_fffe);
      repeat (10) offer_item(mhpq_pkg::OP_EXTRACT, $urandom);
      offer_item(mhpq_pkg::OP_EXTRACT, 32'hffff_ffff);
   endtask

   // stall the output long enough to back up the input, fill past full,
   // then drain past empty
   task automatic test_fill_overflow_drain();
      hold_req_id++;
      repeat (DEPTH + 4) offer_item(mhpq_pkg::OP_INSERT, pick_value());
      repeat (DEPTH + 3) offer_item(mhpq_pkg::OP_EXTRACT, $urandom);
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (120)
         offer_item(($urandom_range(0, 99) < 55) ? mhpq_pkg::OP_INSERT : mhpq_pkg::OP_EXTRACT,
                    pick_value());
      no_idle = 1'b0;
   endtask

   // phases with different insert bias sweep the occupancy up and down
   task automatic test_random_mix();
      int insert_pct;
      repeat (13) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 20;
         endcase
         repeat (40)
            offer_item(($urandom_range(0, 99) < insert_pct) ?
                          mhpq_pkg::OP_INSERT : mhpq_pkg::OP_EXTRACT,
                       pick_value());
      end
   endtask

   // receiver: check each rsp transfer and pace rsp_tready
   initial begin : rsp_side
      int          hold_left;
      int          hold_done_id;
      heap_result_type exp_res;
      logic signed [DATA_W-1:0] got_value;
      logic [OCC_W-1:0]         got_occ;
      hold_left    = 0;
      hold_done_id = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got_value = rsp_tdata[DATA_W-1:0];
            got_occ   = rsp_tdata[DATA_W +: OCC_W];
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected transfer: max_value %0d status %0d occupancy %0d",
                        $time, got_value, rsp_tuser, got_occ);
               mismatch_count++;
            end else begin
               exp_res = pending_results.pop_front();
               if (got_value !== exp_res.max_value) begin
                  $display("%0t: max_value expected %0d actual %0d",
                           $time, exp_res.max_value, got_value);
                  mismatch_count++;
               end
               if (rsp_tuser !== exp_res.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, exp_res.status, rsp_tuser);
                  mismatch_count++;
               end
               if (got_occ !== exp_res.occupancy) begin
                  $display("%0t: occupancy expected %0d actual %0d",
                           $time, exp_res.occupancy, got_occ);
                  mismatch_count++;
               end
            end
         end
         if (hold_req_id != hold_done_id) begin
            hold_done_id = hold_req_id;
            hold_left    = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // end the run if nothing moves on either side for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tb_max_heap_priority_queue_top: FAIL");
            $finish;
         end
      end
   end

   initial begin : main
      mismatch_count = 0;
      no_idle        = 1'b0;
      hold_req_id    = 0;
      heap_count     = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_fill_overflow_drain();
      test_back_to_back();
      test_random_mix();

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb_max_heap_priority_queue_top: PASS");
      else
         $display("tb_max_heap_priority_queue_top: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
